>>> src/dpm_pkg.sv
// Package for the dew point unit: fixed-point widths, constants and shared types.
// Used by every module of the block; depends on nothing else.
package dpm_pkg;

    // Fractional bits of the working fixed-point format.
    localparam int FRAC_BITS = 16;

    // Input and clamped-sample widths.
    localparam int IW  = 16;              // input field width
    localparam int TW  = 14;              // clamped temperature, signed
    localparam int XW  = 14;              // clamped humidity count
    localparam int PW  = 4;               // integer part of log2
    localparam int YW  = FRAC_BITS + 1;   // normalised mantissa
    localparam int RW  = FRAC_BITS + 4;   // log2 result
    localparam int LGW = FRAC_BITS + 3;   // log10 result

    // Temperature term divider.
    localparam int TNW = FRAC_BITS + 24;  // dividend
    localparam int TDW = 22;              // divisor 100*(24312+T)
    localparam int TQW = FRAC_BITS + 2;   // quotient bits

    // Humidity term and sum.
    localparam int MW  = FRAC_BITS + 16;  // magnitude times 10000
    localparam int RK  = FRAC_BITS + 24;  // reciprocal shift
    localparam int RMW = FRAC_BITS + 12;  // reciprocal width
    localparam int T1W = FRAC_BITS + 4;   // humidity term magnitude
    localparam int HW  = FRAC_BITS + 5;   // h, signed

    // Dew point divider.
    localparam int DNW = FRAC_BITS + 12;  // divisor
    localparam int NNW = FRAC_BITS + 27;  // rounded dividend
    localparam int QDW = 14;              // quotient bits
    localparam int DPW = 15;              // output width

    // Clamp limits and saturation values.
    localparam logic signed [IW-1:0] T_MIN  = -16'sd2000;
    localparam logic signed [IW-1:0] T_MAX  = 16'sd5000;
    localparam logic [IW-1:0]        RH_MAX = 16'd10000;
    localparam logic signed [DPW-1:0] DP_MIN = -15'sd9300;
    localparam logic signed [DPW-1:0] DP_MAX = 15'sd5000;
    localparam logic [QDW-1:0]       DP_MIN_MAG = 14'd9300;
    localparam logic [QDW-1:0]       DP_MAX_MAG = 14'd5000;

    // Arithmetic constants.
    localparam logic [30:0]      LOG10_2_Q32 = 31'd1292913986;
    localparam logic [LGW-1:0]   LG_FOUR     = LGW'(4) << FRAC_BITS;
    localparam logic [RMW-1:0]   RECIP_4343  = RMW'((64'd1 << RK) / 64'd4343);
    localparam logic [DNW-1:0]   DEN_BASE    = DNW'(1762) << FRAC_BITS;

    // Clock edges from the edge that accepts a request to the edge that takes its result.
    localparam int LATENCY = FRAC_BITS + 26;

    // Classified sample passed from the front end to the back end.
    typedef struct packed {
        logic [TW-1:0] temp;
        logic [YW-1:0] mant;
        logic [PW-1:0] expo;
        logic          dry;
    } t_front;

endpackage

>>> src/dew_point_from_humidity_unit.sv
// Top level of the dew point unit (Magnus formula, fixed point).
// Depends on dpm_pkg, dpm_front, dpm_queue and dpm_back.
//
//   Channel   Handshake            Payload
//   request   start, busy          i_temperature, i_relative_humidity
//   result    o_valid (strobe)     o_dew_point, o_dry_flag
//
// A request is taken at any edge where start is high and busy is low, one per cycle.
// Its result passes the queue, the stage loaded from the queue head, the squaring
// log2 and temperature divider stages, seven single stages, fourteen dew point
// divider stages and the output register.
// Reset is synchronous and empties the queue and every stage valid bit.
// The receiver cannot stall; the back end advances every cycle, so busy only
// rises if the queue between front and back fills.
module dew_point_from_humidity_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [dpm_pkg::IW-1:0]  i_temperature,
    input  logic [dpm_pkg::IW-1:0]         i_relative_humidity,
    output logic                           o_valid,
    output logic signed [dpm_pkg::DPW-1:0] o_dew_point,
    output logic                           o_dry_flag
);
    import dpm_pkg::*;

    t_front front_item;
    t_front head_item;
    logic   q_empty;
    logic   q_full;

    // Classify and normalise the incoming request.
    dpm_front u_front (
        .i_temperature       (i_temperature),
        .i_relative_humidity (i_relative_humidity),
        .o_item              (front_item)
    );

    // Queue between the two halves.
    dpm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (start && !q_full),
        .i_data  (front_item),
        .i_pop   (!q_empty),
        .o_data  (head_item),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // Arithmetic pipeline.
    dpm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (!q_empty),
        .i_item      (head_item),
        .o_valid     (o_valid),
        .o_dew_point (o_dew_point),
        .o_dry_flag  (o_dry_flag)
    );

    assign busy = q_full;

endmodule

>>> src/dpm_front.sv
// Front end of the dew point unit: clamps a request and normalises the humidity.
// Depends on dpm_pkg.
module dpm_front (
    input  logic signed [dpm_pkg::IW-1:0] i_temperature,
    input  logic [dpm_pkg::IW-1:0]        i_relative_humidity,
    output dpm_pkg::t_front               o_item
);
    import dpm_pkg::*;

    logic signed [IW-1:0] temp_c;
    logic [XW-1:0]        hum;
    logic [PW-1:0]        expo;
    logic [XW+FRAC_BITS-1:0] shifted;

    // Clamp temperature and humidity to their working ranges.
    always_comb begin
        if (i_temperature < T_MIN) begin
            temp_c = T_MIN;
        end else if (i_temperature > T_MAX) begin
            temp_c = T_MAX;
        end else begin
            temp_c = i_temperature;
        end
        if (i_relative_humidity > RH_MAX) begin
            hum = XW'(RH_MAX);
        end else if (i_relative_humidity == '0) begin
            hum = XW'(1);
        end else begin
            hum = i_relative_humidity[XW-1:0];
        end
    end

    // Find the leading one, then normalise the count to [1, 2).
    always_comb begin
        expo = '0;
        for (int i = 0; i < XW; i++) begin
            if (hum[i]) begin
                expo = PW'(i);
            end
        end
        shifted = {hum, {FRAC_BITS{1'b0}}} >> expo;
    end

    assign o_item.temp = temp_c[TW-1:0];
    assign o_item.mant = shifted[YW-1:0];
    assign o_item.expo = expo;
    assign o_item.dry  = (i_relative_humidity == '0);

endmodule

>>> src/dpm_queue.sv
// Two-entry queue between the front and back ends of the dew point unit.
// Depends on dpm_pkg for the item type.
module dpm_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  dpm_pkg::t_front  i_data,
    input  logic             i_pop,
    output dpm_pkg::t_front  o_data,
    output logic             o_empty,
    output logic             o_full
);
    import dpm_pkg::*;

    t_front     r_mem [0:1];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign do_push = i_push && (r_count != 2'd2);
    assign do_pop  = i_pop && (r_count != 2'd0);

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr <= ~r_wr;
            end
            if (do_pop) begin
                r_rd <= ~r_rd;
            end
            r_count <= r_count + 2'(do_push) - 2'(do_pop);
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_empty = (r_count == 2'd0);
    assign o_full  = (r_count == 2'd2);

endmodule

>>> src/dpm_back.sv
// Back end of the dew point unit: log2 by squaring, the temperature term divider,
// the humidity term, and the rounded dew point divider, one request per cycle.
// Depends on dpm_pkg.
module dpm_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  dpm_pkg::t_front                i_item,
    output logic                           o_valid,
    output logic signed [dpm_pkg::DPW-1:0] o_dew_point,
    output logic                           o_dry_flag
);
    import dpm_pkg::*;

    localparam int NS = FRAC_BITS + 2;

    // Log and temperature-division stages.
    logic             r_v    [0:NS];
    logic [YW-1:0]    r_y    [0:FRAC_BITS];
    logic [RW-1:0]    r_r    [0:NS];
    logic [TDW-1:0]   r_trem [0:NS];
    logic [TQW-1:0]   r_tnb  [0:NS];
    logic [TQW-1:0]   r_tq   [0:NS];
    logic [TDW-1:0]   r_td   [0:NS];
    logic             r_tneg [0:NS];
    logic             r_dry  [0:NS];

    logic [TW-2:0]    n_tabs;
    logic [23:0]      n_tmul;
    logic [TNW-1:0]   n_tn;
    logic [TW:0]      n_tsum;

    // Prepare the first stage from the queue head.
    always_comb begin
        n_tabs = i_item.temp[TW-1] ? (TW-1)'(-$signed(i_item.temp))
                                   : i_item.temp[TW-2:0];
        n_tmul = 24'(n_tabs) * 24'd1762;
        n_tn   = {n_tmul, {FRAC_BITS{1'b0}}};
        n_tsum = (TW+1)'(15'd24312 + 15'($signed(i_item.temp)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_y[0]    <= i_item.mant;
        r_r[0]    <= RW'(i_item.expo) << FRAC_BITS;
        r_trem[0] <= n_tn[TNW-1:TQW];
        r_tnb[0]  <= n_tn[TQW-1:0];
        r_tq[0]   <= '0;
        r_td[0]   <= TDW'(n_tsum) * TDW'(100);
        r_tneg[0] <= i_item.temp[TW-1];
        r_dry[0]  <= i_item.dry;
    end

    // One quotient bit per stage, and one squaring step in each of the first FRAC_BITS stages.
    for (genvar k = 0; k < NS; k++) begin : g_iter
        logic [TDW:0]   rem2;
        logic [TDW-1:0] n_rem;
        logic           qb;

        always_comb begin
            rem2 = {r_trem[k], r_tnb[k][TQW-1]};
            if (rem2 >= {1'b0, r_td[k]}) begin
                n_rem = TDW'(rem2 - {1'b0, r_td[k]});
                qb    = 1'b1;
            end else begin
                n_rem = rem2[TDW-1:0];
                qb    = 1'b0;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_trem[k+1] <= n_rem;
            r_tnb[k+1]  <= {r_tnb[k][TQW-2:0], 1'b0};
            r_tq[k+1]   <= {r_tq[k][TQW-2:0], qb};
            r_td[k+1]   <= r_td[k];
            r_tneg[k+1] <= r_tneg[k];
            r_dry[k+1]  <= r_dry[k];
        end

        if (k < FRAC_BITS) begin : g_sq
            logic [2*YW-1:0] sq;
            logic [YW:0]     s;

            always_comb begin
                sq = r_y[k] * r_y[k];
                s  = sq[FRAC_BITS +: YW+1];
            end

            always_ff @(posedge i_clk) begin
                if (s[YW]) begin
                    r_y[k+1] <= s[YW:1];
                    r_r[k+1] <= r_r[k] | (RW'(1) << (FRAC_BITS - 1 - k));
                end else begin
                    r_y[k+1] <= s[YW-1:0];
                    r_r[k+1] <= r_r[k];
                end
            end
        end else begin : g_pass
            always_ff @(posedge i_clk) begin
                r_r[k+1] <= r_r[k];
            end
        end
    end

    // Stage A: log10 and signed temperature term.
    logic [RW+30:0]       a_prod;
    logic                 r_va, r_vb, r_vc, r_vd, r_ve, r_vf;
    logic [LGW-1:0]       r_lg;
    logic signed [HW-1:0] r_t2a, r_t2b, r_t2c, r_t2d;
    logic                 r_drya, r_dryb, r_dryc, r_dryd, r_drye, r_dryf;

    assign a_prod = (RW+31)'(r_r[NS]) * (RW+31)'(LOG10_2_Q32);

    always_ff @(posedge i_clk) begin
        r_lg   <= a_prod[32 +: LGW];
        r_t2a  <= r_tneg[NS] ? -$signed(HW'(r_tq[NS])) : $signed(HW'(r_tq[NS]));
        r_drya <= r_dry[NS];
    end

    // Stage B: magnitude of log10(RH%) - 2, times 10000.
    logic [MW-1:0] r_m_b, r_m_c, r_m_d;
    always_ff @(posedge i_clk) begin
        r_m_b  <= MW'(LG_FOUR - r_lg) * MW'(10000);
        r_t2b  <= r_t2a;
        r_dryb <= r_drya;
    end

    // Stage C: multiply by the reciprocal of 4343.
    logic [MW+RMW-1:0] r_prod;
    always_ff @(posedge i_clk) begin
        r_prod <= (MW+RMW)'(r_m_b) * (MW+RMW)'(RECIP_4343);
        r_m_c  <= r_m_b;
        r_t2c  <= r_t2b;
        r_dryc <= r_dryb;
    end

    // Stage D: trial quotient and its product back.
    logic [T1W-1:0] r_q0;
    logic [MW-1:0]  r_qm;
    always_ff @(posedge i_clk) begin
        r_q0   <= r_prod[RK +: T1W];
        r_qm   <= MW'(r_prod[RK +: T1W]) * MW'(4343);
        r_m_d  <= r_m_c;
        r_t2d  <= r_t2c;
        r_dryd <= r_dryc;
    end

    // Stage E: correct the quotient by one and form h.
    logic [MW-1:0]        e_rem;
    logic [T1W-1:0]       e_q1;
    logic signed [HW-1:0] r_h;
    always_comb begin
        e_rem = r_m_d - r_qm;
        e_q1  = r_q0 + T1W'(e_rem >= MW'(4343));
    end
    always_ff @(posedge i_clk) begin
        r_h    <= r_t2d - $signed(HW'(e_q1));
        r_drye <= r_dryd;
    end

    // Stage F: numerator magnitude and denominator of the dew point.
    logic [HW-2:0]  f_habs;
    logic [NNW-1:0] r_num;
    logic [DNW-1:0] r_den_f;
    logic           r_neg_f;
    assign f_habs = r_h[HW-1] ? (HW-1)'(-r_h) : r_h[HW-2:0];
    always_ff @(posedge i_clk) begin
        r_num   <= NNW'(f_habs) * NNW'(2431200);
        r_den_f <= r_h[HW-1] ? DEN_BASE + DNW'(f_habs) * DNW'(100)
                             : DEN_BASE - DNW'(f_habs) * DNW'(100);
        r_neg_f <= r_h[HW-1];
        r_dryf  <= r_drye;
    end

    // Stage G: add half the divisor for rounding, load the divider.
    logic [NNW-1:0] g_n2;
    logic [DNW-1:0] r_drem [0:QDW];
    logic [QDW-1:0] r_dnb  [0:QDW];
    logic [QDW-1:0] r_dq   [0:QDW];
    logic [DNW-1:0] r_dden [0:QDW];
    logic           r_dneg [0:QDW];
    logic           r_ddry [0:QDW];
    logic           r_dv   [0:QDW];

    assign g_n2 = r_num + NNW'(r_den_f >> 1);

    always_ff @(posedge i_clk) begin
        r_drem[0] <= g_n2[QDW +: DNW];
        r_dnb[0]  <= g_n2[QDW-1:0];
        r_dq[0]   <= '0;
        r_dden[0] <= r_den_f;
        r_dneg[0] <= r_neg_f;
        r_ddry[0] <= r_dryf;
    end

    // Valid bits of the single stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va    <= 1'b0;
            r_vb    <= 1'b0;
            r_vc    <= 1'b0;
            r_vd    <= 1'b0;
            r_ve    <= 1'b0;
            r_vf    <= 1'b0;
            r_dv[0] <= 1'b0;
        end else begin
            r_va    <= r_v[NS];
            r_vb    <= r_va;
            r_vc    <= r_vb;
            r_vd    <= r_vc;
            r_ve    <= r_vd;
            r_vf    <= r_ve;
            r_dv[0] <= r_vf;
        end
    end

    // Dew point divider, one quotient bit per stage.
    for (genvar j = 0; j < QDW; j++) begin : g_div
        logic [DNW:0]   rem2;
        logic [DNW-1:0] n_rem;
        logic           qb;

        always_comb begin
            rem2 = {r_drem[j], r_dnb[j][QDW-1]};
            if (rem2 >= {1'b0, r_dden[j]}) begin
                n_rem = DNW'(rem2 - {1'b0, r_dden[j]});
                qb    = 1'b1;
            end else begin
                n_rem = rem2[DNW-1:0];
                qb    = 1'b0;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[j+1] <= 1'b0;
            end else begin
                r_dv[j+1] <= r_dv[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_drem[j+1] <= n_rem;
            r_dnb[j+1]  <= {r_dnb[j][QDW-2:0], 1'b0};
            r_dq[j+1]   <= {r_dq[j][QDW-2:0], qb};
            r_dden[j+1] <= r_dden[j];
            r_dneg[j+1] <= r_dneg[j];
            r_ddry[j+1] <= r_ddry[j];
        end
    end

    // Output stage: sign, saturation and the dry case.
    logic signed [DPW-1:0] n_dp;
    always_comb begin
        priority if (r_ddry[QDW]) begin
            n_dp = DP_MIN;
        end else if (r_dneg[QDW]) begin
            n_dp = (r_dq[QDW] > DP_MIN_MAG) ? DP_MIN : -$signed(DPW'(r_dq[QDW]));
        end else begin
            n_dp = (r_dq[QDW] > DP_MAX_MAG) ? DP_MAX : $signed(DPW'(r_dq[QDW]));
        end
    end

    logic r_out_v;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= r_dv[QDW];
        end
    end

    always_ff @(posedge i_clk) begin
        o_dew_point <= n_dp;
        o_dry_flag  <= r_ddry[QDW];
    end

    assign o_valid = r_out_v;

endmodule

>>> src/dpm_checker.sv
// Port-level checks for the dew point unit, and the bind that attaches them.
// Depends on dpm_pkg and dew_point_from_humidity_unit.
module dpm_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           start,
    input logic                           busy,
    input logic [dpm_pkg::IW-1:0]         i_relative_humidity,
    input logic                           o_valid,
    input logic signed [dpm_pkg::DPW-1:0] o_dew_point,
    input logic                           o_dry_flag
);
    import dpm_pkg::*;

    // A reset cycle leaves no result strobe behind it.
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result strobe just after reset");

    // Every result belongs to a request taken a fixed time before.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LATENCY))
        else $error("result without a matching request");

    // A request with zero humidity comes back flagged dry.
    a_dry_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_relative_humidity == '0 |-> ##LATENCY (o_valid && o_dry_flag))
        else $error("dry request not reported");

    // A dry result carries the lower saturation value.
    a_dry_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_dry_flag |-> o_dew_point == DP_MIN)
        else $error("dry result with wrong dew point");

    // Results stay within the saturation range.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_dew_point >= DP_MIN) && (o_dew_point <= DP_MAX))
        else $error("dew point out of range");

endmodule

bind dew_point_from_humidity_unit dpm_checker u_dpm_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .start               (start),
    .busy                (busy),
    .i_relative_humidity (i_relative_humidity),
    .o_valid             (o_valid),
    .o_dew_point         (o_dew_point),
    .o_dry_flag          (o_dry_flag)
);
